// ===== hw/rtl/cle_pkg.sv =====
`timescale 1ns / 1ps

package cle_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [7:0]  KEY_UNDERSCORE = 8'h5F;
  localparam logic [7:0]  KEY_SPACE      = 8'h20;
  localparam logic [15:0] CODE_EMPTY     = 16'h0000;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_ERASE  = 3'd1,
    OP_LEFT   = 3'd2,
    OP_RIGHT  = 3'd3,
    OP_TOGGLE = 3'd4,
    OP_EMIT   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ML_WR,
    ST_MR_WR,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  typedef struct packed {
    logic add_wr;
    logic erase;
    logic toggle;
    logic ovf_out;
    logic empty_out;
    logic ml_rd;
    logic ml_wr;
    logic mr_rd;
    logic mr_wr;
    logic em_start;
    logic em_rd;
    logic em_ld;
    logic em_clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic left_zero;
    logic right_zero;
    logic total_zero;
    logic emit_last;
    logic out_free;
  } status_t;

  function automatic logic [15:0] to_korean(input logic [7:0] c);
    logic [15:0] r;
    unique case (c)
      KEY_SPACE: r = 16'h0020;
      "r": r = 16'h3131;
      "R": r = 16'h3132;
      "s": r = 16'h3134;
      "e": r = 16'h3137;
      "E": r = 16'h3138;
      "f": r = 16'h3139;
      "a": r = 16'h3141;
      "q": r = 16'h3142;
      "Q": r = 16'h3143;
      "t": r = 16'h3145;
      "T": r = 16'h3146;
      "d": r = 16'h3147;
      "w": r = 16'h3148;
      "W": r = 16'h3149;
      "c": r = 16'h314A;
      "z": r = 16'h314B;
      "x": r = 16'h314C;
      "v": r = 16'h314D;
      "g": r = 16'h314E;
      "k": r = 16'h314F;
      "o": r = 16'h3150;
      "i": r = 16'h3151;
      "O": r = 16'h3152;
      "j": r = 16'h3153;
      "p": r = 16'h3154;
      "u": r = 16'h3155;
      "P": r = 16'h3156;
      "h": r = 16'h3157;
      "y": r = 16'h315B;
      "n": r = 16'h315C;
      "b": r = 16'h3160;
      "m": r = 16'h3161;
      "l": r = 16'h3163;
      default: r = CODE_EMPTY;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cle_ctrl.sv =====
`timescale 1ns / 1ps

module cle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  cle_pkg::status_t  status,
  output cle_pkg::cmd_t     cmd
);
  import cle_pkg::*;

  state_t state;
  state_t state_next;
  logic   need_out;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    need_out   = ((op == OP_ADD) && status.full) ||
                 ((op == OP_EMIT) && status.total_zero);
    in_stall   = (state != ST_IDLE) || (need_out && !status.out_free);
    accept     = in_valid && !in_stall;
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (op)
            OP_ADD: begin
              if (status.full) begin
                cmd.ovf_out = 1'b1;
              end else begin
                cmd.add_wr = 1'b1;
              end
            end
            OP_ERASE: begin
              cmd.erase = !status.left_zero;
            end
            OP_LEFT: begin
              if (!status.left_zero) begin
                cmd.ml_rd  = 1'b1;
                state_next = ST_ML_WR;
              end
            end
            OP_RIGHT: begin
              if (!status.right_zero) begin
                cmd.mr_rd  = 1'b1;
                state_next = ST_MR_WR;
              end
            end
            OP_TOGGLE: begin
              cmd.toggle = 1'b1;
            end
            OP_EMIT: begin
              if (status.total_zero) begin
                cmd.empty_out = 1'b1;
              end else begin
                cmd.em_start = 1'b1;
                state_next   = ST_EM_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ML_WR: begin
        cmd.ml_wr  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MR_WR: begin
        cmd.mr_wr  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_EM_RD: begin
        cmd.em_rd  = 1'b1;
        state_next = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (status.out_free) begin
          cmd.em_ld = 1'b1;
          if (status.emit_last) begin
            cmd.em_clear = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cle_dpath.sv =====
`timescale 1ns / 1ps

module cle_dpath (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        char_code,
  input  cle_pkg::cmd_t     cmd,
  output cle_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       char_out,
  output logic              last,
  output logic              empty_res,
  output logic              overflow
);
  import cle_pkg::*;

  logic [15:0]       mem [CAPACITY];
  logic [15:0]       rdata;
  logic [CNT_W-1:0]  left_count;
  logic [CNT_W-1:0]  right_count;
  logic [CNT_W-1:0]  emit_idx;
  logic              korean_mode;

  logic [CNT_W-1:0]  total;
  logic [7:0]        key;
  logic [15:0]       add_code;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  left_m1;
  logic [CNT_W-1:0]  right_top;
  logic [CNT_W-1:0]  right_near;
  logic [CNT_W-1:0]  emit_addr;
  logic              out_load;

  always_comb begin
    total      = left_count + right_count;
    key        = (char_code == KEY_UNDERSCORE) ? KEY_SPACE : char_code;
    add_code   = korean_mode ? to_korean(key) : {8'h00, key};
    left_m1    = left_count - CNT_W'(1);
    right_top  = CNT_W'(CAPACITY - 1) - right_count;
    right_near = CNT_W'(CAPACITY) - right_count;
    emit_addr  = (emit_idx < left_count) ? emit_idx
                 : (emit_idx + CNT_W'(CAPACITY) - total);

    wr_en   = cmd.add_wr || cmd.ml_wr || cmd.mr_wr;
    wr_addr = left_count[ADDR_W-1:0];
    wr_data = rdata;
    if (cmd.add_wr) begin
      wr_data = add_code;
    end else if (cmd.ml_wr) begin
      wr_addr = right_top[ADDR_W-1:0];
    end

    rd_en   = cmd.ml_rd || cmd.mr_rd || cmd.em_rd;
    rd_addr = emit_addr[ADDR_W-1:0];
    if (cmd.ml_rd) begin
      rd_addr = left_m1[ADDR_W-1:0];
    end else if (cmd.mr_rd) begin
      rd_addr = right_near[ADDR_W-1:0];
    end

    out_load = cmd.ovf_out || cmd.empty_out || cmd.em_ld;

    status.full       = (total >= CNT_W'(CAPACITY));
    status.left_zero  = (left_count == '0);
    status.right_zero = (right_count == '0);
    status.total_zero = (total == '0);
    status.emit_last  = (emit_idx == total - CNT_W'(1));
    status.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      korean_mode <= 1'b0;
      emit_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.add_wr || cmd.mr_wr) begin
        left_count <= left_count + CNT_W'(1);
      end else if (cmd.erase || cmd.ml_wr) begin
        left_count <= left_m1;
      end else if (cmd.em_clear) begin
        left_count <= '0;
      end
      if (cmd.ml_wr) begin
        right_count <= right_count + CNT_W'(1);
      end else if (cmd.mr_wr) begin
        right_count <= right_count - CNT_W'(1);
      end else if (cmd.em_clear) begin
        right_count <= '0;
      end
      if (cmd.toggle) begin
        korean_mode <= !korean_mode;
      end
      if (cmd.em_start) begin
        emit_idx <= '0;
      end else if (cmd.em_ld) begin
        emit_idx <= emit_idx + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_out  <= cmd.em_ld ? rdata : CODE_EMPTY;
      last      <= cmd.empty_out || (cmd.em_ld && status.emit_last);
      empty_res <= cmd.empty_out;
      overflow  <= cmd.ovf_out;
    end
  end

endmodule

// ===== hw/rtl/cursor_line_editor_buffer_top.sv =====
`timescale 1ns / 1ps
// Channel | Handshake           | Word
// in      | in_valid, in_stall   | op[2:0], char_code[7:0]
// out     | out_valid, out_stall | char_out[15:0], last, empty_res, overflow
//
// Add, erase, toggle: done when accepted. Move left/right: memory read, then write.
// Emit: a start step, then for each stored character a read and an output load, plus stalls.
// Reset (rst, sync) empties the line and selects English mode; memory is not cleared.
// in_stall stays high while a move or an emit is in progress.
// An add on a full line or an emit on an empty line is held off while the output register is full and stalled.
module cursor_line_editor_buffer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] char_out,
  output logic        last,
  output logic        empty_res,
  output logic        overflow
);
  import cle_pkg::*;

  cmd_t    cmd;
  status_t status;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  cle_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last      (last),
    .empty_res (empty_res),
    .overflow  (overflow)
  );

endmodule
